### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_STR     = 7'b0000010,
        MODE_ESC     = 7'b0000100,
        MODE_HEX     = 7'b0001000,
        MODE_SUR_BS  = 7'b0010000,
        MODE_SUR_U   = 7'b0100000,
        MODE_LOW_HEX = 7'b1000000
    } mode_t;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_FF = 8'h0c;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_N = 8'h6e;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] CH_LC_U = 8'h75;

    localparam logic [5:0]  HI_SUR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SUR_TAG = 6'b110111;
    localparam logic [10:0] PLANE_OFFSET = 11'h040;

    // one group of results caused by a single input beat
    typedef struct packed {
        logic [1:0]      status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] data;
    } grp_t;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic grp_t utf8_bmp(input logic [15:0] cp);
        grp_t g;
        g = '0;
        g.status = ST_DATA;
        if (cp[15:7] == 9'd0) begin
            g.last_idx = 2'd0;
            g.data[0]  = {1'b0, cp[6:0]};
        end
        else if (cp[15:11] == 5'd0) begin
            g.last_idx = 2'd1;
            g.data[0]  = {3'b110, cp[10:6]};
            g.data[1]  = {2'b10, cp[5:0]};
        end
        else begin
            g.last_idx = 2'd2;
            g.data[0]  = {4'b1110, cp[15:12]};
            g.data[1]  = {2'b10, cp[11:6]};
            g.data[2]  = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    function automatic grp_t utf8_pair(input logic [20:0] cp);
        grp_t g;
        g = '0;
        g.status   = ST_DATA;
        g.last_idx = 2'd3;
        g.data[0]  = {5'b11110, cp[20:18]};
        g.data[1]  = {2'b10, cp[17:12]};
        g.data[2]  = {2'b10, cp[11:6]};
        g.data[3]  = {2'b10, cp[5:0]};
        return g;
    endfunction

endpackage

### rtl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// valid/ready channels for raw text beats and decoded result beats
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

### rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// decode state machine: one text beat in, at most one result group out
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       emit,
    output grp_t       grp
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hs_reg, hs_next;

    logic        bad;
    logic        done;
    logic        ws;
    logic        emit_data;
    logic [4:0]  hd;
    logic [15:0] acc_shift;
    logic [10:0] pair_hi;
    grp_t        data_grp;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        hs_next   = hs_reg;
        bad       = 1'b0;
        done      = 1'b0;
        ws        = 1'b0;
        emit_data = 1'b0;
        data_grp  = '0;
        hd        = hex_digit(in_byte);
        acc_shift = {acc_reg[11:0], hd[3:0]};
        pair_hi   = {1'b0, hs_reg} + PLANE_OFFSET;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (in_byte == CH_QUOTE)
                    mode_next = MODE_STR;
                else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                         in_byte == CH_LF || in_byte == CH_CR)
                    ws = 1'b1;
                else
                    bad = 1'b1;
            end
            MODE_STR:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    done      = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (in_byte < CH_SPACE)
                    bad = 1'b1;
                else if (in_byte == CH_BSLASH)
                    mode_next = MODE_ESC;
                else
                begin
                    emit_data        = 1'b1;
                    data_grp.data[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                emit_data = 1'b1;
                case (in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: data_grp.data[0] = in_byte;
                    CH_LC_B: data_grp.data[0] = CH_BS;
                    CH_LC_F: data_grp.data[0] = CH_FF;
                    CH_LC_N: data_grp.data[0] = CH_LF;
                    CH_LC_R: data_grp.data[0] = CH_CR;
                    CH_LC_T: data_grp.data[0] = CH_TAB;
                    CH_LC_U:
                    begin
                        emit_data = 1'b0;
                        mode_next = MODE_HEX;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    default:
                    begin
                        emit_data = 1'b0;
                        bad       = 1'b1;
                    end
                endcase
            end
            MODE_HEX, MODE_LOW_HEX:
            begin
                if (!hd[4])
                    bad = 1'b1;
                else
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (mode_reg == MODE_HEX)
                        begin
                            if (acc_shift[15:10] == HI_SUR_TAG)
                            begin
                                hs_next   = acc_shift[9:0];
                                mode_next = MODE_SUR_BS;
                            end
                            else if (acc_shift[15:10] == LO_SUR_TAG)
                                bad = 1'b1;
                            else
                            begin
                                emit_data = 1'b1;
                                data_grp  = utf8_bmp(acc_shift);
                                mode_next = MODE_STR;
                            end
                        end
                        else if (acc_shift[15:10] != LO_SUR_TAG)
                            bad = 1'b1;
                        else
                        begin
                            emit_data = 1'b1;
                            data_grp  = utf8_pair({pair_hi[10:0], acc_shift[9:0]});
                            mode_next = MODE_STR;
                        end
                    end
                end
            end
            MODE_SUR_BS:
            begin
                if (in_byte == CH_BSLASH)
                    mode_next = MODE_SUR_U;
                else
                    bad = 1'b1;
            end
            MODE_SUR_U:
            begin
                if (in_byte == CH_LC_U)
                begin
                    mode_next = MODE_LOW_HEX;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else
                    bad = 1'b1;
            end
            default:
                bad = 1'b1;
        endcase

        // text ends with a string still open, or ends on whitespace outside a string
        if (final_byte && !bad && !done && (mode_next != MODE_IDLE || ws))
            bad = 1'b1;

        if (bad)
        begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            hs_next   = '0;
        end

        grp = data_grp;
        if (bad || done)
        begin
            grp        = '0;
            grp.status = bad ? ST_BAD : ST_DONE;
        end
        emit = bad || done || emit_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            hs_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            hs_reg   <= hs_next;
        end
    end

endmodule

### rtl/jsu_serial.sv
// ----------------------------------------------------------------------------
// jsu_serial
// result register: holds one group and, while the result port is ready, sends its beats one per cycle
// ----------------------------------------------------------------------------
module jsu_serial
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  grp_t        grp,
    output logic        space,
    jsu_out_if.source   res
);

    grp_t       grp_reg;
    logic       vld_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       last;

    assign last            = (idx_reg == grp_reg.last_idx);
    assign take            = vld_reg && res.ready;
    assign space           = !vld_reg || (take && last);
    assign res.valid       = vld_reg;
    assign res.out_byte    = grp_reg.data[idx_reg];
    assign res.status      = grp_reg.status;
    assign res.last_of_run = last;

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (take)
        begin
            if (last)
                vld_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

### rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// json string literal unescaper producing utf-8, taking, unless held by its result port, one text beat per cycle
// ----------------------------------------------------------------------------
// first result of a beat is offered the cycle after the beat is taken
// throughput: one text beat per cycle while each beat gives at most one result and the result port is ready
// a beat giving k results (k up to 4) holds the input until the single result port
// takes the last of them from the result register
// reset: decoder goes idle with hex state cleared, result register empties
module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     byte_ch,
    jsu_out_if.source  result_ch
);

    logic accept;
    logic emit;
    logic space;
    grp_t grp;

    assign byte_ch.ready = space;
    assign accept        = byte_ch.valid && space;

    jsu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (byte_ch.in_byte),
        .final_byte (byte_ch.final_byte),
        .emit       (emit),
        .grp        (grp)
    );

    jsu_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept && emit),
        .grp   (grp),
        .space (space),
        .res   (result_ch)
    );

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.status != ST_DATA |-> result_ch.last_of_run)
        else $error("done or malformed result not last of its run");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.status == ST_DATA ||
                             result_ch.status == ST_DONE ||
                             result_ch.status == ST_BAD))
        else $error("unknown status code");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ch.ready |-> (!result_ch.valid ||
                           (result_ch.ready && result_ch.last_of_run)))
        else $error("input ready while a group is still draining");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.ready && !result_ch.last_of_run
        |=> result_ch.valid && result_ch.status == ST_DATA && !byte_ch.ready ||
            result_ch.valid && result_ch.status == ST_DATA && result_ch.ready &&
            result_ch.last_of_run)
        else $error("multi-beat run broken");

endmodule
